@@ rtl/s2tc_pkg.sv @@
`default_nettype none

package s2tc_pkg;

    localparam int TIME_W            = 48;
    localparam int MAG_W             = TIME_W - 1;
    localparam int RATE_Q8_W         = 16;
    localparam int RATE_W            = 9;
    localparam int PROD_W            = MAG_W + RATE_W;
    localparam int FRAME_W           = 8;
    localparam int SEC_W             = 6;
    localparam int MIN_W             = 6;
    localparam int HOUR_W            = 20;
    localparam int STEP_BITS         = 8;
    localparam int SEXAG             = 60;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [RATE_Q8_W-1:0] RATE_Q8_RESET = 16'd6144;

    // Round 8.8 rate to nearest integer, half up; zero becomes one.
    function automatic logic [RATE_W-1:0] round_rate(input logic [RATE_Q8_W-1:0] q8);
        logic [RATE_Q8_W:0] sum;
        logic [RATE_W-1:0]  r;
        sum = {1'b0, q8} + (RATE_Q8_W + 1)'(128);
        r   = sum[RATE_Q8_W:RATE_Q8_W-RATE_W+1];
        if (r == '0) begin
            r = RATE_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/s2tc_time_if.sv @@
`default_nettype none

interface s2tc_time_if;
    import s2tc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TIME_W-1:0] time_q16;

    modport source (output valid, output time_q16, input ready);
    modport sink   (input valid, input time_q16, output ready);
endinterface

`default_nettype wire

@@ rtl/s2tc_cfg_if.sv @@
`default_nettype none

interface s2tc_cfg_if;
    import s2tc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [RATE_Q8_W-1:0] frame_rate_q8;

    modport source (output valid, output frame_rate_q8, input ready);
    modport sink   (input valid, input frame_rate_q8, output ready);
endinterface

`default_nettype wire

@@ rtl/s2tc_tc_if.sv @@
`default_nettype none

interface s2tc_tc_if;
    import s2tc_pkg::*;

    logic               valid;
    logic               ready;
    logic [HOUR_W-1:0]  hours;
    logic [MIN_W-1:0]   minutes;
    logic [SEC_W-1:0]   whole_seconds;
    logic [FRAME_W-1:0] frame_number;

    modport source (output valid, output hours, output minutes, output whole_seconds,
                    output frame_number, input ready);
    modport sink   (input valid, input hours, input minutes, input whole_seconds,
                    input frame_number, output ready);
endinterface

`default_nettype wire

@@ rtl/s2tc_scale.sv @@
`default_nettype none

module s2tc_scale #(
    parameter int FRACTION_BITS = s2tc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [s2tc_pkg::TIME_W-1:0]    i_time_q16,
    input  wire logic [s2tc_pkg::RATE_W-1:0]           i_rate,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [s2tc_pkg::PROD_W-FRACTION_BITS-1:0]  o_total
);
    import s2tc_pkg::*;

    localparam int TOT_W = PROD_W - FRACTION_BITS;
    localparam logic [PROD_W-1:0] HALF = PROD_W'((1 << FRACTION_BITS) >> 1);

    logic              r_a_valid;
    logic [MAG_W-1:0]  r_a_mag;
    logic              r_b_valid;
    logic [TOT_W-1:0]  r_b_total;

    logic              ce_a;
    logic              ce_b;
    logic [MAG_W-1:0]  n_a_mag;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] n_b_total;

    assign ce_b = !r_b_valid || i_ready;
    assign ce_a = !r_a_valid || ce_b;

    // negative time clamps to zero
    assign n_a_mag   = i_time_q16[TIME_W-1] ? '0 : i_time_q16[MAG_W-1:0];
    assign prod      = PROD_W'(r_a_mag) * PROD_W'(i_rate);
    assign n_b_total = (prod + HALF) >> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ce_a) begin
                r_a_valid <= i_valid;
            end
            if (ce_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce_a && i_valid) begin
            r_a_mag <= n_a_mag;
        end
        if (ce_b && r_a_valid) begin
            r_b_total <= n_b_total[TOT_W-1:0];
        end
    end

    assign o_ready = ce_a;
    assign o_valid = r_b_valid;
    assign o_total = r_b_total;

endmodule

`default_nettype wire

@@ rtl/s2tc_div.sv @@
`default_nettype none

// Pipelined restoring divider, STEP_BITS quotient bits per stage.
// Divisor and an optional side payload travel with each transaction.
module s2tc_div #(
    parameter int DW = 40,
    parameter int VW = 9,
    parameter int SW = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [DW-1:0]               i_dividend,
    input  wire logic [VW-1:0]               i_divisor,
    input  wire logic [((SW > 0) ? SW : 1)-1:0] i_side,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [DW-1:0]                    o_quotient,
    output logic [VW-1:0]                    o_remainder,
    output logic [((SW > 0) ? SW : 1)-1:0]   o_side
);
    import s2tc_pkg::*;

    localparam int NS  = (DW + STEP_BITS - 1) / STEP_BITS;
    localparam int SWP = (SW > 0) ? SW : 1;

    logic            r_v [NS];
    logic [DW-1:0]   r_q [NS];
    logic [VW-1:0]   r_r [NS];
    logic [VW-1:0]   r_d [NS];
    logic [SWP-1:0]  r_s [NS];
    logic [NS:0]     ce;

    assign ce[NS] = i_ready;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic           v_src;
        logic [DW-1:0]  q_src;
        logic [VW-1:0]  r_src;
        logic [VW-1:0]  d_src;
        logic [SWP-1:0] s_src;
        logic [DW-1:0]  q_nx;
        logic [VW-1:0]  r_nx;
        logic [VW:0]    trial;

        if (s == 0) begin : g_first
            assign v_src = i_valid;
            assign q_src = i_dividend;
            assign r_src = '0;
            assign d_src = i_divisor;
            assign s_src = i_side;
        end else begin : g_next
            assign v_src = r_v[s-1];
            assign q_src = r_q[s-1];
            assign r_src = r_r[s-1];
            assign d_src = r_d[s-1];
            assign s_src = r_s[s-1];
        end

        assign ce[s] = !r_v[s] || ce[s+1];

        // dividend bits shift out the top while quotient bits shift in
        always_comb begin
            q_nx  = q_src;
            r_nx  = r_src;
            trial = '0;
            for (int k = 0; k < STEP_BITS; k++) begin
                if (s * STEP_BITS + k < DW) begin
                    trial = {r_nx, q_nx[DW-1]};
                    q_nx  = {q_nx[DW-2:0], 1'b0};
                    if (trial >= {1'b0, d_src}) begin
                        r_nx    = VW'(trial - {1'b0, d_src});
                        q_nx[0] = 1'b1;
                    end else begin
                        r_nx = trial[VW-1:0];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (ce[s]) begin
                r_v[s] <= v_src;
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce[s] && v_src) begin
                r_q[s] <= q_nx;
                r_r[s] <= r_nx;
                r_d[s] <= d_src;
                r_s[s] <= s_src;
            end
        end
    end

    assign o_ready     = ce[0];
    assign o_valid     = r_v[NS-1];
    assign o_quotient  = r_q[NS-1];
    assign o_remainder = r_r[NS-1];
    assign o_side      = r_s[NS-1];

endmodule

`default_nettype wire

@@ rtl/seconds_to_timecode.sv @@
`default_nettype none

// Seconds to timecode converter.
// i_time (valid/ready) carries a signed Q32.16 time in seconds; o_tc (valid/ready)
// returns hours, minutes, whole_seconds and frame_number, one per input transaction.
// i_cfg writes frame_rate_q8 (8.8 frames/s); it is always ready and must only be
// written while nothing is in flight. The rate is rounded to an integer (minimum 1)
// when written. Negative times give 0:0:0:0.
// Pipeline: clamp stage, multiply/round stage, then three restoring dividers
// (by rate, by 60, by 60) retiring 8 quotient bits per stage.
// Throughput is one transaction per cycle while o_tc is ready. Every stage
// holds its own valid bit and loads when empty or when the stage after it moves,
// so a stall at o_tc only backs up as far as the bubbles allow and nothing is
// lost or repeated.
// Reset clears all valid bits and sets the rate to 24 frames/s.
module seconds_to_timecode #(
    parameter int FRACTION_BITS = s2tc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    s2tc_cfg_if.sink     i_cfg,
    s2tc_time_if.sink    i_time,
    s2tc_tc_if.source    o_tc
);
    import s2tc_pkg::*;

    localparam int TOT_W  = PROD_W - FRACTION_BITS;
    localparam int MINS_W = TOT_W - $clog2(SEXAG) + 1;

    logic [RATE_W-1:0]  r_rate;

    logic               sc_valid;
    logic               sc_ready;
    logic [TOT_W-1:0]   sc_total;

    logic               d1_valid;
    logic               d1_ready;
    logic [TOT_W-1:0]   d1_quot;
    logic [RATE_W-1:0]  d1_rem;

    logic               d2_valid;
    logic               d2_ready;
    logic [TOT_W-1:0]   d2_quot;
    logic [SEC_W-1:0]   d2_rem;
    logic [FRAME_W-1:0] d2_side;

    logic [MINS_W-1:0]  d3_quot;
    logic [MIN_W-1:0]   d3_rem;
    logic [FRAME_W+SEC_W-1:0] d3_side;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= round_rate(RATE_Q8_RESET);
        end else if (i_cfg.valid) begin
            r_rate <= round_rate(i_cfg.frame_rate_q8);
        end
    end

    s2tc_scale #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_time.valid),
        .o_ready    (i_time.ready),
        .i_time_q16 (i_time.time_q16),
        .i_rate     (r_rate),
        .o_valid    (sc_valid),
        .i_ready    (sc_ready),
        .o_total    (sc_total)
    );

    // total frames / rate -> whole seconds, frame
    s2tc_div #(
        .DW(TOT_W),
        .VW(RATE_W),
        .SW(0)
    ) u_div_rate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sc_valid),
        .o_ready     (sc_ready),
        .i_dividend  (sc_total),
        .i_divisor   (r_rate),
        .i_side      (1'b0),
        .o_valid     (d1_valid),
        .i_ready     (d1_ready),
        .o_quotient  (d1_quot),
        .o_remainder (d1_rem),
        .o_side      ()
    );

    // seconds / 60 -> minutes, seconds within minute
    s2tc_div #(
        .DW(TOT_W),
        .VW(SEC_W),
        .SW(FRAME_W)
    ) u_div_sec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (d1_valid),
        .o_ready     (d1_ready),
        .i_dividend  (d1_quot),
        .i_divisor   (SEC_W'(SEXAG)),
        .i_side      (d1_rem[FRAME_W-1:0]),
        .o_valid     (d2_valid),
        .i_ready     (d2_ready),
        .o_quotient  (d2_quot),
        .o_remainder (d2_rem),
        .o_side      (d2_side)
    );

    // minutes / 60 -> hours, minutes within hour
    s2tc_div #(
        .DW(MINS_W),
        .VW(MIN_W),
        .SW(FRAME_W + SEC_W)
    ) u_div_min (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (d2_valid),
        .o_ready     (d2_ready),
        .i_dividend  (d2_quot[MINS_W-1:0]),
        .i_divisor   (MIN_W'(SEXAG)),
        .i_side      ({d2_side, d2_rem}),
        .o_valid     (o_tc.valid),
        .i_ready     (o_tc.ready),
        .o_quotient  (d3_quot),
        .o_remainder (d3_rem),
        .o_side      (d3_side)
    );

    assign o_tc.hours         = d3_quot[HOUR_W-1:0];
    assign o_tc.minutes       = d3_rem;
    assign o_tc.whole_seconds = d3_side[SEC_W-1:0];
    assign o_tc.frame_number  = d3_side[FRAME_W+SEC_W-1:SEC_W];

endmodule

`default_nettype wire

@@ rtl/s2tc_chk.sv @@
`default_nettype none

module s2tc_chk (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    s2tc_cfg_if.sink     i_cfg,
    s2tc_time_if.sink    i_time,
    s2tc_tc_if.source    o_tc
);
    import s2tc_pkg::*;

    // the pipeline is empty on the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_tc.valid)
        else $error("result valid right after reset");

    a_minutes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tc.valid |-> (o_tc.minutes < MIN_W'(SEXAG)))
        else $error("minutes out of range");

    a_seconds_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tc.valid |-> (o_tc.whole_seconds < SEC_W'(SEXAG)))
        else $error("seconds out of range");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid |-> i_cfg.ready)
        else $error("config write refused");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tc.valid && !o_tc.ready) |=>
            (o_tc.valid && $stable(o_tc.hours) && $stable(o_tc.minutes)
             && $stable(o_tc.whole_seconds) && $stable(o_tc.frame_number)))
        else $error("stalled result changed");

endmodule

bind seconds_to_timecode s2tc_chk u_s2tc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_cfg   (i_cfg),
    .i_time  (i_time),
    .o_tc    (o_tc)
);

`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import s2tc_pkg::*;

    localparam int FRAC_BITS = FRACTION_BITS_DEF;
    localparam logic [63:0] HALF_LSB = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
    localparam logic [TIME_W-1:0] MAX_TIME = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic [TIME_W-1:0] MIN_TIME = {1'b1, {(TIME_W-1){1'b0}}};
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 86;
    localparam int TAIL_CYCLES     = 40;

    typedef struct packed {
        logic [HOUR_W-1:0]  hours;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   whole_seconds;
        logic [FRAME_W-1:0] frame_number;
    } t_tc;

    typedef enum logic [1:0] {JOB_TIME, JOB_RATE, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind         kind;
        logic [TIME_W-1:0] value;
    } t_job;

    logic i_clk;
    logic i_rst_n;

    s2tc_cfg_if  cfg_if ();
    s2tc_time_if time_if ();
    s2tc_tc_if   tc_if ();

    seconds_to_timecode #(
        .FRACTION_BITS (FRAC_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_time  (time_if),
        .o_tc    (tc_if)
    );

    t_job                 jobs[$];
    t_tc                  expect_tc[$];
    logic [RATE_Q8_W-1:0] rate_q8_model;
    int unsigned          gap_left, stall_left;
    int unsigned          send_calm, recv_calm;
    int unsigned          fail_count, times_sent, neg_sent, rate_writes, tc_checked;

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned fps_of(logic [RATE_Q8_W-1:0] q8);
        int unsigned r;
        r = (int'(q8) + 128) >> 8;
        return (r == 0) ? 1 : r;
    endfunction

    function automatic t_tc timecode_of(logic [TIME_W-1:0] t, logic [RATE_Q8_W-1:0] q8);
        logic [63:0] fps, mag, frames, secs, mins;
        t_tc         tc;
        fps    = 64'(fps_of(q8));
        mag    = t[TIME_W-1] ? 64'd0 : {{(64-TIME_W){1'b0}}, t};
        frames = (mag * fps + HALF_LSB) >> FRAC_BITS;
        secs   = frames / fps;
        mins   = secs / SEXAG;
        tc.frame_number  = FRAME_W'(frames % fps);
        tc.whole_seconds = SEC_W'(secs % SEXAG);
        tc.minutes       = MIN_W'(mins % SEXAG);
        tc.hours         = HOUR_W'(mins / SEXAG);
        return tc;
    endfunction

    // Idle count per transaction, with occasional runs of back-to-back traffic
    function automatic int unsigned next_pause(ref int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [TIME_W-1:0] at_seconds(longint unsigned s);
        return TIME_W'(s << FRAC_BITS);
    endfunction

    function automatic logic [TIME_W-1:0] random_time(int unsigned fps);
        logic [63:0] r, n;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return r[TIME_W-1:0];
            1: return {1'b1, r[TIME_W-2:0]};
            2: return TIME_W'(r % (64'd120 << FRAC_BITS));
            3, 4: return TIME_W'(r % (64'd360000 << FRAC_BITS));
            5: return MAX_TIME - TIME_W'(r % 64'd5000);
            6, 7: begin
                // first time stamp that rounds up to frame n, or the one just below
                n = 64'd1 + r % 64'd10_000_000;
                n = ((n << FRAC_BITS) - HALF_LSB + 64'(fps) - 64'd1) / 64'(fps);
                return TIME_W'(n - 64'($urandom_range(0, 1)));
            end
            8: begin
                n = r % 64'd400_000;
                return TIME_W'((n << FRAC_BITS) - 64'($urandom_range(0, 1)));
            end
            default: return r[TIME_W-1:0] >> $urandom_range(0, TIME_W - 1);
        endcase
    endfunction

    function automatic void push_job(t_job_kind kind, logic [TIME_W-1:0] value);
        t_job j;
        j.kind  = kind;
        j.value = value;
        jobs.insert(jobs.size(), j);
    endfunction

    function automatic void push_time(logic [TIME_W-1:0] t);
        push_job(JOB_TIME, t);
    endfunction

    function automatic void push_rate(logic [RATE_Q8_W-1:0] q8);
        push_job(JOB_RATE, TIME_W'(q8));
    endfunction

    // Driver: time stamps and rate writes, predicting each accepted time stamp
    always @(posedge i_clk) begin
        logic send_time, send_rate;
        send_time = 1'b0;
        send_rate = 1'b0;
        if (!i_rst_n) begin
            time_if.valid         <= 1'b0;
            time_if.time_q16      <= '0;
            cfg_if.valid          <= 1'b0;
            cfg_if.frame_rate_q8  <= '0;
            rate_q8_model = RATE_Q8_RESET;
            gap_left      = 0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                rate_q8_model = cfg_if.frame_rate_q8;
                rate_writes++;
            end
            if (time_if.valid && time_if.ready) begin
                expect_tc.insert(expect_tc.size(),
                                 timecode_of(time_if.time_q16, rate_q8_model));
                times_sent++;
                if (time_if.time_q16[TIME_W-1]) begin
                    neg_sent++;
                end
                gap_left = next_pause(send_calm);
            end
            if ((time_if.valid && !time_if.ready) || (cfg_if.valid && !cfg_if.ready)) begin
                send_time = time_if.valid;
                send_rate = cfg_if.valid;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (jobs.size() != 0) begin
                case (jobs[0].kind)
                    JOB_TIME: begin
                        send_time = 1'b1;
                        time_if.time_q16 <= jobs[0].value;
                        void'(jobs.pop_front());
                    end
                    // rate changes only with nothing in flight
                    JOB_RATE: if (expect_tc.size() == 0) begin
                        send_rate = 1'b1;
                        cfg_if.frame_rate_q8 <= jobs[0].value[RATE_Q8_W-1:0];
                        void'(jobs.pop_front());
                    end
                    JOB_DRAIN: if (expect_tc.size() == 0) begin
                        void'(jobs.pop_front());
                    end
                    default: void'(jobs.pop_front());
                endcase
            end
            time_if.valid <= send_time;
            cfg_if.valid  <= send_rate;
        end
    end

    // Monitor: timecode checks and backpressure
    always @(posedge i_clk) begin
        t_tc want;
        if (!i_rst_n) begin
            tc_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (tc_if.valid && tc_if.ready) begin
                if (expect_tc.size() == 0) begin
                    $error("timecode %0d:%0d:%0d:%0d with no time stamp pending", tc_if.hours,
                           tc_if.minutes, tc_if.whole_seconds, tc_if.frame_number);
                    fail_count++;
                end else begin
                    want = expect_tc.pop_front();
                    tc_checked++;
                    if (tc_if.hours !== want.hours) begin
                        $error("hours: expected %0d, actual %0d", want.hours, tc_if.hours);
                        fail_count++;
                    end
                    if (tc_if.minutes !== want.minutes) begin
                        $error("minutes: expected %0d, actual %0d", want.minutes, tc_if.minutes);
                        fail_count++;
                    end
                    if (tc_if.whole_seconds !== want.whole_seconds) begin
                        $error("whole_seconds: expected %0d, actual %0d", want.whole_seconds,
                               tc_if.whole_seconds);
                        fail_count++;
                    end
                    if (tc_if.frame_number !== want.frame_number) begin
                        $error("frame_number: expected %0d, actual %0d", want.frame_number,
                               tc_if.frame_number);
                        fail_count++;
                    end
                end
                stall_left = next_pause(recv_calm);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            tc_if.ready <= (stall_left == 0);
        end
    end

    initial begin
        logic [RATE_Q8_W-1:0] phase_rates [N_PHASES];
        int unsigned          fps;
        i_rst_n              = 1'b0;
        time_if.valid        = 1'b0;
        time_if.time_q16     = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.frame_rate_q8 = '0;
        tc_if.ready          = 1'b0;

        // default 24 fps: clamping, rounding edges, second/minute/hour rollovers
        push_time('0);
        push_time(TIME_W'(1));
        push_time('1);
        push_time(MIN_TIME);
        push_time(MAX_TIME);
        push_time(TIME_W'(32768));
        push_time(TIME_W'(1365));
        push_time(TIME_W'(1366));
        push_time(at_seconds(60) - 1);
        push_time(at_seconds(60));
        push_time(at_seconds(3600) - 1);
        push_time(at_seconds(3600));
        push_time(at_seconds(86400));
        push_time(48'h5555_5555_5555);
        push_time(48'hAAAA_AAAA_AAAA);
        // rate register rounds to zero, used as one frame per second
        push_rate('0);
        push_time(TIME_W'(32767));
        push_time(TIME_W'(32768));
        push_time(MAX_TIME);
        push_time(at_seconds(3599) + TIME_W'(32768));
        // register above its range: 256 fps, frame number up to 255
        push_rate('1);
        push_time(MAX_TIME);
        push_time(TIME_W'(65151));
        push_time(TIME_W'(65152));
        push_time(MIN_TIME);

        phase_rates = '{16'd7672, 16'd127, 16'd65407, 16'd65408, 16'd384, 16'd128,
                        16'd6399, 16'd7680, 16'd0, 16'd0, 16'd0, 16'd0};
        for (int p = 8; p < N_PHASES; p++) begin
            phase_rates[p] = RATE_Q8_W'($urandom_range(0, 65535));
        end
        for (int p = 0; p < N_PHASES; p++) begin
            push_rate(phase_rates[p]);
            fps = fps_of(phase_rates[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2) begin
                    push_job(JOB_DRAIN, '0);
                end
                push_time(random_time(fps));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (jobs.size() != 0 || time_if.valid || cfg_if.valid || expect_tc.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d time stamps (%0d negative) across %0d frame rate writes,",
                 times_sent, neg_sent, rate_writes);
        $display("%0d timecodes checked, %0d mismatches.", tc_checked, fail_count);
        if (fail_count == 0) begin
            $display("[seconds_to_timecode] OK");
        end else begin
            $display("[seconds_to_timecode] ERROR");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Timed out with %0d time stamps pending", expect_tc.size());
        $display("[seconds_to_timecode] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ seconds_to_timecode.f @@
rtl/s2tc_pkg.sv
rtl/s2tc_time_if.sv
rtl/s2tc_cfg_if.sv
rtl/s2tc_tc_if.sv
rtl/s2tc_scale.sv
rtl/s2tc_div.sv
rtl/seconds_to_timecode.sv
rtl/s2tc_chk.sv
verif/tb_top.sv
